[design/bpn_pkg.sv]
`default_nettype none

package bpn_pkg;

  // Item kinds carried by the operation field.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_TRIGGER = 2'd2;

  // Instruction opcodes. The remaining code yields zero.
  localparam logic [2:0] OPC_INV  = 3'd0;
  localparam logic [2:0] OPC_AND  = 3'd1;
  localparam logic [2:0] OPC_NAND = 3'd2;
  localparam logic [2:0] OPC_OR   = 3'd3;
  localparam logic [2:0] OPC_NOR  = 3'd4;
  localparam logic [2:0] OPC_XOR  = 3'd5;
  localparam logic [2:0] OPC_XNOR = 3'd6;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] instr_opcode;
    logic [4:0] src_a;
    logic       src_a_is_input;
    logic [4:0] src_b;
    logic       src_b_is_input;
    logic [3:0] target_reg;
    logic       gen_out;
    logic [4:0] signal_index;
    logic       signal_value;
    logic       signal_is_seq;
  } in_item_t;

  typedef struct packed {
    logic [31:0] output_bits;
    logic        outputs_changed;
    logic        evaluated;
    logic        program_full;
  } out_item_t;

  // One stored program word.
  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] src_a;
    logic       src_a_is_input;
    logic [4:0] src_b;
    logic       src_b_is_input;
    logic [3:0] target_reg;
    logic       gen_out;
  } instr_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

[design/bpn_alu.sv]
`default_nettype none

module bpn_alu
  import bpn_pkg::*;
#(
  parameter int NUM_INPUTS    = 32,
  parameter int NUM_REGISTERS = 16
) (
  input  instr_t                   instr,
  input  logic [NUM_INPUTS-1:0]    inputs_cur,
  input  logic [NUM_REGISTERS-1:0] regs,
  output logic                     result
);

  logic in_a, in_b, reg_a, reg_b, x, y;

  // Indices beyond the configured inputs or registers read as zero.
  always_comb begin
    in_a  = 1'b0;
    in_b  = 1'b0;
    reg_a = 1'b0;
    reg_b = 1'b0;
    for (int j = 0; j < NUM_INPUTS; j++) begin
      if (32'(instr.src_a) == j) in_a = inputs_cur[j];
      if (32'(instr.src_b) == j) in_b = inputs_cur[j];
    end
    for (int j = 0; j < NUM_REGISTERS; j++) begin
      if (32'(instr.src_a) == j) reg_a = regs[j];
      if (32'(instr.src_b) == j) reg_b = regs[j];
    end
    x = instr.src_a_is_input ? in_a : reg_a;
    y = instr.src_b_is_input ? in_b : reg_b;
  end

  always_comb begin
    unique case (instr.opcode)
      OPC_INV:  result = ~x;
      OPC_AND:  result = x & y;
      OPC_NAND: result = ~(x & y);
      OPC_OR:   result = x | y;
      OPC_NOR:  result = ~(x | y);
      OPC_XOR:  result = x ^ y;
      OPC_XNOR: result = ~(x ^ y);
      default:  result = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/boolean_program_node_top.sv]
// Channel | Ports                          | Payload
// input   | in_valid, in_ready, in_data    | in_item_t, one command per beat
// result  | out_valid, out_ready, out_data | out_item_t, one result per beat
//
// A load, a set or trigger that does not evaluate, or an unknown operation has
// its result registered at the accepting edge, as has a run of an empty program.
// Otherwise an evaluation reads one program word per cycle and executes it in the
// cycle after its read. Synchronous reset on rst_n clears length, input copies,
// outputs and control; program memory is not cleared. A held result stalls the
// input unless it is taken in the same cycle.
`default_nettype none

module boolean_program_node_top
  import bpn_pkg::*;
#(
  parameter int MAX_INSTRUCTIONS = 64,
  parameter int NUM_INPUTS       = 32,
  parameter int NUM_REGISTERS    = 16,
  parameter int NUM_OUTPUTS      = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW   = (MAX_INSTRUCTIONS > 1) ? $clog2(MAX_INSTRUCTIONS) : 1;
  localparam int LW   = $clog2(MAX_INSTRUCTIONS + 1);
  localparam int KW   = $clog2(NUM_OUTPUTS + 1);
  localparam int EXTW = (NUM_OUTPUTS > 32) ? NUM_OUTPUTS : 32;

  function automatic logic [31:0] visible_bits(input logic [NUM_OUTPUTS-1:0] v);
    logic [EXTW-1:0] e;
    e = EXTW'(v);
    return e[31:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [LW-1:0]            prog_len_r, prog_len_nxt;
  logic [NUM_INPUTS-1:0]    cur_r, cur_nxt;
  logic [NUM_INPUTS-1:0]    next_in_r, next_in_nxt;
  logic [NUM_OUTPUTS-1:0]   outv_r, outv_nxt;
  logic [NUM_REGISTERS-1:0] wregs_r, wregs_nxt;
  logic                     seen_r, seen_nxt;
  logic [LW-1:0]            exec_idx_r, exec_idx_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic                     changed_r, changed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  instr_t                   mem [MAX_INSTRUCTIONS];
  instr_t                   rd_data_r;
  instr_t                   wr_data;
  logic                     mem_we;
  logic [AW-1:0]            rd_addr;
  logic                     accept;
  logic                     run;
  logic                     full;
  logic                     alu_res;

  assign wr_data = '{opcode:         in_data.instr_opcode,
                     src_a:          in_data.src_a,
                     src_a_is_input: in_data.src_a_is_input,
                     src_b:          in_data.src_b,
                     src_b_is_input: in_data.src_b_is_input,
                     target_reg:     in_data.target_reg,
                     gen_out:        in_data.gen_out};

  bpn_alu #(
    .NUM_INPUTS   (NUM_INPUTS),
    .NUM_REGISTERS(NUM_REGISTERS)
  ) u_alu (
    .instr     (rd_data_r),
    .inputs_cur(cur_r),
    .regs      (wregs_r),
    .result    (alu_res)
  );

  // Appends go to the entry at the current length; reads feed the executor.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[prog_len_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    prog_len_nxt  = prog_len_r;
    cur_nxt       = cur_r;
    next_in_nxt   = next_in_r;
    outv_nxt      = outv_r;
    wregs_nxt     = wregs_r;
    seen_nxt      = seen_r;
    exec_idx_nxt  = exec_idx_r;
    k_nxt         = k_r;
    changed_nxt   = changed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    run           = 1'b0;
    full          = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_LOAD: begin
              if (prog_len_r < LW'(MAX_INSTRUCTIONS)) begin
                mem_we       = 1'b1;
                prog_len_nxt = prog_len_r + LW'(1);
              end else begin
                full = 1'b1;
              end
            end
            OP_SET: begin
              for (int j = 0; j < NUM_INPUTS; j++) begin
                if (32'(in_data.signal_index) == j) begin
                  next_in_nxt[j] = in_data.signal_value;
                  if (!in_data.signal_is_seq) begin
                    run        = cur_r[j] != in_data.signal_value;
                    cur_nxt[j] = in_data.signal_value;
                  end
                end
              end
            end
            OP_TRIGGER: begin
              run      = !seen_r || (cur_r != next_in_r);
              cur_nxt  = next_in_r;
              seen_nxt = 1'b1;
            end
            default: ;
          endcase

          if (run && (prog_len_r != '0)) begin
            state_nxt     = ST_RUN;
            wregs_nxt     = '0;
            k_nxt         = '0;
            exec_idx_nxt  = '0;
            changed_nxt   = 1'b0;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{output_bits:     visible_bits(outv_r),
                              outputs_changed: 1'b0,
                              evaluated:       run,
                              program_full:    full};
          end
        end
      end

      ST_RUN: begin
        for (int j = 0; j < NUM_REGISTERS; j++) begin
          if (32'(rd_data_r.target_reg) == j) wregs_nxt[j] = alu_res;
        end
        // Outputs are numbered among generating instructions; extras drop.
        if (rd_data_r.gen_out && (32'(k_r) < NUM_OUTPUTS)) begin
          for (int j = 0; j < NUM_OUTPUTS; j++) begin
            if (32'(k_r) == j) begin
              outv_nxt[j] = alu_res;
              if (outv_r[j] != alu_res) changed_nxt = 1'b1;
            end
          end
          k_nxt = k_r + KW'(1);
        end
        exec_idx_nxt = exec_idx_r + LW'(1);
        rd_addr      = exec_idx_nxt[AW-1:0];
        if (exec_idx_nxt == prog_len_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{output_bits:     visible_bits(outv_nxt),
                            outputs_changed: changed_nxt,
                            evaluated:       1'b1,
                            program_full:    1'b0};
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prog_len_r  <= '0;
      cur_r       <= '0;
      next_in_r   <= '0;
      outv_r      <= '0;
      wregs_r     <= '0;
      seen_r      <= 1'b0;
      exec_idx_r  <= '0;
      k_r         <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prog_len_r  <= prog_len_nxt;
      cur_r       <= cur_nxt;
      next_in_r   <= next_in_nxt;
      outv_r      <= outv_nxt;
      wregs_r     <= wregs_nxt;
      seen_r      <= seen_nxt;
      exec_idx_r  <= exec_idx_nxt;
      k_r         <= k_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prog_len_r <= LW'(MAX_INSTRUCTIONS))
    else $error("program length beyond capacity");

  a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (exec_idx_r < prog_len_r))
    else $error("executing past the end of the program");

  a_run_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !out_valid_r)
    else $error("result beat pending during an evaluation");

  a_run_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> $stable(prog_len_r))
    else $error("program changed during an evaluation");
`endif

endmodule

`default_nettype wire

[verif/boolean_program_node_checker.sv]
`timescale 1ns / 1ps

module boolean_program_node_checker
  import bpn_pkg::*;
#(
  parameter int MAX_INSTRUCTIONS = 64,
  parameter int NUM_INPUTS       = 32,
  parameter int NUM_REGISTERS    = 16,
  parameter int NUM_OUTPUTS      = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        results_pending,
  output int        beats_seen,
  output int        runs_seen,
  output int        loads_dropped
);

  instr_t                   prog_words [MAX_INSTRUCTIONS];
  int unsigned              prog_len;
  logic [NUM_INPUTS-1:0]    sig_now;
  logic [NUM_INPUTS-1:0]    sig_next;
  logic [NUM_OUTPUTS-1:0]   out_vec;
  logic [NUM_REGISTERS-1:0] work_regs;
  logic                     trigger_seen;
  out_item_t                results_due [$];
  out_item_t                due;
  out_item_t                fresh;

  function automatic logic operand(logic [4:0] idx, logic from_signals);
    if (from_signals) return (idx < NUM_INPUTS) ? sig_now[idx] : 1'b0;
    return (idx < NUM_REGISTERS) ? work_regs[idx] : 1'b0;
  endfunction

  // Runs the stored program once and reports whether any output bit moved.
  function automatic logic evaluate_program();
    logic        changed;
    logic        x;
    logic        y;
    logic        r;
    int unsigned k;
    changed   = 1'b0;
    k         = 0;
    work_regs = '0;
    for (int unsigned i = 0; i < prog_len; i++) begin
      x = operand(prog_words[i].src_a, prog_words[i].src_a_is_input);
      y = operand(prog_words[i].src_b, prog_words[i].src_b_is_input);
      case (prog_words[i].opcode)
        OPC_INV:  r = !x;
        OPC_AND:  r = x & y;
        OPC_NAND: r = !(x & y);
        OPC_OR:   r = x | y;
        OPC_NOR:  r = !(x | y);
        OPC_XOR:  r = x ^ y;
        OPC_XNOR: r = !(x ^ y);
        default:  r = 1'b0;
      endcase
      if (prog_words[i].target_reg < NUM_REGISTERS) work_regs[prog_words[i].target_reg] = r;
      if (prog_words[i].gen_out) begin
        // Outputs past the last one are numbered but go nowhere.
        if (k < NUM_OUTPUTS) begin
          if (out_vec[k] != r) changed = 1'b1;
          out_vec[k] = r;
        end
        k++;
      end
    end
    return changed;
  endfunction

  function automatic out_item_t node_result(in_item_t cmd);
    out_item_t res;
    instr_t    word;
    logic      run;
    res = '0;
    run = 1'b0;
    case (cmd.operation)
      OP_LOAD: begin
        if (prog_len < MAX_INSTRUCTIONS) begin
          word.opcode         = cmd.instr_opcode;
          word.src_a          = cmd.src_a;
          word.src_a_is_input = cmd.src_a_is_input;
          word.src_b          = cmd.src_b;
          word.src_b_is_input = cmd.src_b_is_input;
          word.target_reg     = cmd.target_reg;
          word.gen_out        = cmd.gen_out;
          prog_words[prog_len] = word;
          prog_len++;
        end else begin
          res.program_full = 1'b1;
        end
      end
      OP_SET: begin
        if (cmd.signal_index < NUM_INPUTS) begin
          sig_next[cmd.signal_index] = cmd.signal_value;
          if (!cmd.signal_is_seq) begin
            run = sig_now[cmd.signal_index] != cmd.signal_value;
            sig_now[cmd.signal_index] = cmd.signal_value;
          end
        end
      end
      OP_TRIGGER: begin
        run          = !trigger_seen || (sig_now != sig_next);
        sig_now      = sig_next;
        trigger_seen = 1'b1;
      end
      default: ;
    endcase
    if (run) res.outputs_changed = evaluate_program();
    res.evaluated = run;
    for (int i = 0; i < 32 && i < NUM_OUTPUTS; i++) res.output_bits[i] = out_vec[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] beat %0d: %s", $time, beats_seen, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prog_len        = 0;
      sig_now         = '0;
      sig_next        = '0;
      out_vec         = '0;
      work_regs       = '0;
      trigger_seen    = 1'b0;
      results_due     = {};
      mismatches      = 0;
      results_pending = 0;
      beats_seen      = 0;
      runs_seen       = 0;
      loads_dropped   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          due = results_due.pop_front();
          if (out_data.output_bits !== due.output_bits)
            report_mismatch($sformatf("output_bits %h, want %h",
                                      out_data.output_bits, due.output_bits));
          if (out_data.outputs_changed !== due.outputs_changed)
            report_mismatch($sformatf("outputs_changed %b, want %b",
                                      out_data.outputs_changed, due.outputs_changed));
          if (out_data.evaluated !== due.evaluated)
            report_mismatch($sformatf("evaluated %b, want %b",
                                      out_data.evaluated, due.evaluated));
          if (out_data.program_full !== due.program_full)
            report_mismatch($sformatf("program_full %b, want %b",
                                      out_data.program_full, due.program_full));
        end
        beats_seen++;
      end
      if (in_valid && in_ready) begin
        fresh = node_result(in_data);
        if (fresh.evaluated) runs_seen++;
        if (fresh.program_full) loads_dropped++;
        results_due.insert(results_due.size(), fresh);
      end
      results_pending = results_due.size();
    end
  end

endmodule

[verif/boolean_program_node_top_tb.sv]
`timescale 1ns / 1ps

module boolean_program_node_top_tb;
  import bpn_pkg::*;

  localparam int          HALF_PERIOD_NS   = 10;
  localparam int          RESET_CYCLES     = 9;
  localparam int          RANDOM_COMMANDS  = 1850;
  localparam int          PROG_DEPTH       = 64;
  localparam int          HOLD_AFTER_BEATS = 300;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 80;
  localparam longint      TIMEOUT_NS       = 40_000_000;
  localparam logic [1:0]  OP_UNDEF         = 2'd3;
  localparam logic [2:0]  OPC_UNDEF        = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int results_pending;
  int beats_seen;
  int runs_seen;
  int loads_dropped;
  int commands_sent;
  int directed_count;
  int loads_sent;
  int burst_left;

  in_item_t directed [$];

  always #(HALF_PERIOD_NS) clk = ~clk;

  boolean_program_node_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  boolean_program_node_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .results_pending (results_pending),
    .beats_seen      (beats_seen),
    .runs_seen       (runs_seen),
    .loads_dropped   (loads_dropped)
  );

  // Fields that the operation does not use carry random noise.
  function automatic in_item_t noise_cmd(logic [1:0] op);
    logic [31:0] raw;
    in_item_t    c;
    raw         = $urandom;
    c           = raw[$bits(in_item_t)-1:0];
    c.operation = op;
    return c;
  endfunction

  function automatic in_item_t load_cmd(logic [2:0] opc, logic [4:0] a, logic a_in,
                                        logic [4:0] b, logic b_in, logic [3:0] tgt,
                                        logic gen);
    in_item_t c;
    c                = noise_cmd(OP_LOAD);
    c.instr_opcode   = opc;
    c.src_a          = a;
    c.src_a_is_input = a_in;
    c.src_b          = b;
    c.src_b_is_input = b_in;
    c.target_reg     = tgt;
    c.gen_out        = gen;
    return c;
  endfunction

  function automatic in_item_t set_cmd(logic [4:0] idx, logic value, logic seq);
    in_item_t c;
    c               = noise_cmd(OP_SET);
    c.signal_index  = idx;
    c.signal_value  = value;
    c.signal_is_seq = seq;
    return c;
  endfunction

  function automatic void add_directed(in_item_t c);
    directed.insert(directed.size(), c);
  endfunction

  // Sets and triggers dominate; loads are more frequent until PROG_DEPTH loads are sent.
  function automatic in_item_t random_cmd(int loads_so_far);
    int unsigned r;
    int unsigned load_weight;
    in_item_t    c;
    r           = $urandom_range(0, 99);
    load_weight = (loads_so_far < PROG_DEPTH) ? 20 : 4;
    if (r < load_weight) begin
      c         = noise_cmd(OP_LOAD);
      c.gen_out = ($urandom_range(0, 9) < 7);
    end else if (r < load_weight + 45) begin
      c = noise_cmd(OP_SET);
    end else if (r < 97) begin
      c = noise_cmd(OP_TRIGGER);
    end else begin
      c = noise_cmd(OP_UNDEF);
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_cmd(input in_item_t cmd);
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    commands_sent++;
    if (cmd.operation == OP_LOAD) loads_sent++;
  endtask

  task automatic input_gap();
    int unsigned r;
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 120);
      return;
    end
    if (r < 60) return;
    gap = (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    rst_n          = 1'b0;
    commands_sent  = 0;
    loads_sent     = 0;
    burst_left     = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // The first trigger runs even an empty program; the second has nothing to do.
    add_directed(noise_cmd(OP_TRIGGER));
    add_directed(noise_cmd(OP_TRIGGER));
    add_directed(noise_cmd(OP_UNDEF));
    add_directed(load_cmd(OPC_INV,   5'd0,  1'b1, 5'd9,  1'b0, 4'd0,  1'b1));
    add_directed(load_cmd(OPC_AND,   5'd0,  1'b1, 5'd31, 1'b1, 4'd1,  1'b1));
    add_directed(load_cmd(OPC_NAND,  5'd0,  1'b0, 5'd1,  1'b0, 4'd2,  1'b1));
    // Register 20 does not exist and reads as zero.
    add_directed(load_cmd(OPC_OR,    5'd31, 1'b1, 5'd20, 1'b0, 4'd15, 1'b1));
    add_directed(load_cmd(OPC_NOR,   5'd15, 1'b0, 5'd5,  1'b1, 4'd3,  1'b0));
    add_directed(load_cmd(OPC_XOR,   5'd3,  1'b0, 5'd0,  1'b1, 4'd4,  1'b1));
    add_directed(load_cmd(OPC_XNOR,  5'd31, 1'b1, 5'd31, 1'b0, 4'd5,  1'b1));
    add_directed(load_cmd(OPC_UNDEF, 5'd0,  1'b1, 5'd0,  1'b1, 4'd6,  1'b1));
    add_directed(set_cmd(5'd0,  1'b1, 1'b0));
    add_directed(set_cmd(5'd0,  1'b1, 1'b0));
    add_directed(set_cmd(5'd31, 1'b1, 1'b0));
    add_directed(set_cmd(5'd5,  1'b1, 1'b1));
    add_directed(noise_cmd(OP_TRIGGER));
    add_directed(noise_cmd(OP_TRIGGER));
    add_directed(set_cmd(5'd5,  1'b0, 1'b1));
    add_directed(set_cmd(5'd5,  1'b0, 1'b0));
    add_directed(noise_cmd(OP_TRIGGER));
    add_directed(set_cmd(5'd0,  1'b0, 1'b0));
    add_directed(set_cmd(5'd31, 1'b0, 1'b1));
    add_directed(set_cmd(5'd31, 1'b0, 1'b0));
    add_directed(noise_cmd(OP_TRIGGER));
    directed_count = directed.size();

    foreach (directed[i]) begin
      send_cmd(directed[i]);
      input_gap();
    end
    while (commands_sent < directed_count + RANDOM_COMMANDS) begin
      send_cmd(random_cmd(loads_sent));
      input_gap();
    end
    in_valid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d commands driven (%0d directed), %0d result beats checked.",
             commands_sent, directed_count, beats_seen);
    $display("Summary: %0d program runs, %0d loads refused by a full program.",
             runs_seen, loads_dropped);
    if (mismatches == 0) begin
      $display("boolean_program_node_top_tb passed");
    end else begin
      $display("boolean_program_node_top_tb failed");
    end
    $finish;
  end

  // Result side: short and occasional long stalls, stall-free stretches, and
  // one long hold-off so the block backs up into its input.
  initial begin
    int unsigned r;
    int unsigned gap;
    int          free_left;
    bit          held_long;
    out_ready = 1'b0;
    free_left = 0;
    held_long = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && beats_seen >= HOLD_AFTER_BEATS) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (free_left > 0) begin
        out_ready <= 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          free_left = $urandom_range(30, 150);
          out_ready <= 1'b1;
        end else if (r < 30) begin
          gap = (r < 27) ? $urandom_range(1, 3) : $urandom_range(20, 80);
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("boolean_program_node_top_tb failed");
    $finish;
  end

endmodule

[sim.f]
design/bpn_pkg.sv
design/bpn_alu.sv
design/boolean_program_node_top.sv
verif/boolean_program_node_checker.sv
verif/boolean_program_node_top_tb.sv
